// ===== design/ufp_pkg.sv =====
// shared types and constants for the union-find percolation engine
// no dependencies; imported by the engine and the testbench
`default_nettype none
package ufp_pkg;

	localparam int SiteW  = 12;
	localparam int CountW = 13;
	localparam int NbSlots = 8;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_ADD   = 1'b1;

	// one command item
	typedef struct packed {
		logic              func;
		logic [SiteW-1:0]  site;
		logic [NbSlots-1:0] neighbor_valid;
		logic [SiteW-1:0]  neighbor_a;
		logic [SiteW-1:0]  neighbor_b;
		logic [SiteW-1:0]  neighbor_c;
		logic [SiteW-1:0]  neighbor_d;
		logic [SiteW-1:0]  neighbor_e;
		logic [SiteW-1:0]  neighbor_f;
		logic [SiteW-1:0]  neighbor_g;
		logic [SiteW-1:0]  neighbor_h;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic              spans;
		logic [CountW-1:0] sites_added;
		logic [CountW-1:0] largest_size;
		logic [SiteW-1:0]  largest_label;
	} out_item_t;

endpackage
`default_nettype wire

// ===== design/ufp_store.sv =====
// single-port-write, single-port-read site memory with registered read data
// depends on nothing; instantiated by the top level
`default_nettype none
module ufp_store #(
	parameter int DW    = 26,
	parameter int DEPTH = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [DW-1:0]              wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [DW-1:0]              rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/union_find_percolation_engine.sv =====
// Weighted union-find site percolation engine. An item is taken when start is high and
// busy is low; its single result appears on result for one cycle with done high, and
// the receiver cannot hold it off. After reset and after every start item the block
// sweeps the site memory empty, one site per cycle, with busy high throughout.
// An add item has a site check; a new site then runs the slot loop, in which each valid
// neighbor slot is read, an occupied neighbor has its root found by walking the parent
// links and then compressing the path walked, and each merge rewrites both roots.
// The spanning scan of the four boundary lines follows: each occupied boundary site has
// its root found the same way, a line ends at its first site in the largest cluster or
// runs to its end, and the result is posted last. Every find step goes through the one
// read port of the site memory, so these steps run one after another.
// depends on ufp_pkg and ufp_store
`default_nettype none
module union_find_percolation_engine #(
	parameter int SIDE          = 64,
	parameter int SITES         = 4096,
	parameter int MAX_NEIGHBORS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire ufp_pkg::in_item_t cmd,
	output logic                   done,
	output ufp_pkg::out_item_t     result
);
	import ufp_pkg::*;

	localparam int AW = $clog2(SITES);
	localparam int IW = $clog2(SITES + SIDE) + 1;
	localparam int KW = $clog2(MAX_NEIGHBORS + 1);
	localparam int TopEnd   = (SIDE < SITES) ? SIDE : SITES;
	localparam int BotStart = (SITES > SIDE) ? SITES - SIDE : 0;

	localparam logic [2:0] LN_TOP   = 3'd0;
	localparam logic [2:0] LN_BOT   = 3'd1;
	localparam logic [2:0] LN_LEFT  = 3'd2;
	localparam logic [2:0] LN_RIGHT = 3'd3;
	localparam logic [2:0] LN_DONE  = 3'd4;

	typedef struct packed {
		logic          occ;
		logic [AW-1:0] parent;
		logic [AW:0]   size;
	} entry_t;

	localparam int DW = $bits(entry_t);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CHK, ST_NB, ST_NB_CHK, ST_WALK, ST_COMP,
		ST_MERGE, ST_MERGE2, ST_SPAN, ST_SCAN, ST_SCAN_CHK, ST_SCAN_CMP
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        site_q;
	logic [NbSlots-1:0]   nbv_q;
	logic [SiteW-1:0]     nb_q [NbSlots];
	logic [KW-1:0]        k_q;
	logic [AW-1:0]        r1_q;
	logic [AW:0]          r1size_q;
	logic [AW-1:0]        cur_q;
	logic [AW-1:0]        fstart_q;
	logic [AW-1:0]        root_q;
	logic [AW:0]          rootsize_q;
	logic                 caller_q;
	logic [2:0]           line_q;
	logic [IW-1:0]        idx_q;
	logic [3:0]           flags_q;
	logic [AW:0]          big_size_q;
	logic [AW-1:0]        big_root_q;
	logic [AW:0]          total_q;
	logic [AW-1:0]        wp_addr_q;
	entry_t               wp_data_q;
	logic                 done_q;
	out_item_t            result_q;

	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	entry_t               mem_wdata;
	logic [DW-1:0]        rdata_raw;
	entry_t               rd;

	logic [SiteW-1:0]     nb_sel;
	logic                 nb_ok, site_ok, comp_stop, r1_joins;
	logic [AW:0]          sum;
	logic [IW-1:0]        ln_end, ln_step;

	// boundary line walk parameters
	function automatic logic [IW-1:0] line_start(input logic [2:0] l);
		case (l)
			LN_BOT:   line_start = IW'(BotStart);
			LN_RIGHT: line_start = IW'(SIDE - 1);
			default:  line_start = '0;
		endcase
	endfunction

	always_comb begin
		ln_step = (line_q == LN_LEFT || line_q == LN_RIGHT) ? IW'(SIDE) : IW'(1);
		ln_end  = (line_q == LN_TOP) ? IW'(TopEnd) : IW'(SITES);
	end

	ufp_store #(.DW(DW), .DEPTH(SITES)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata_raw)
	);

	assign rd = entry_t'(rdata_raw);

	// shared decisions
	always_comb begin
		nb_sel    = nb_q[3'(k_q)];
		nb_ok     = (k_q < KW'(MAX_NEIGHBORS)) && nbv_q[3'(k_q)] && (32'(nb_sel) < SITES);
		site_ok   = 32'(cmd.site) < SITES;
		comp_stop = (cur_q == root_q) || (rd.parent == root_q);
		r1_joins  = r1size_q < rootsize_q;
		sum       = r1size_q + rootsize_q;
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = cur_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_IDLE: begin
				mem_re    = start && cmd.func == FUNC_ADD && site_ok;
				mem_raddr = AW'(cmd.site);
			end
			ST_CHK: begin
				mem_we    = !rd.occ;
				mem_waddr = site_q;
				mem_wdata = '{occ: 1'b1, parent: site_q, size: (AW+1)'(1)};
			end
			ST_NB: begin
				mem_re    = nb_ok;
				mem_raddr = AW'(nb_sel);
			end
			ST_NB_CHK, ST_SCAN_CHK: begin
				mem_re = rd.occ;
			end
			ST_WALK: begin
				mem_re    = 1'b1;
				mem_raddr = (rd.parent == cur_q) ? fstart_q : rd.parent;
			end
			ST_COMP: begin
				mem_we    = !comp_stop;
				mem_wdata = '{occ: rd.occ, parent: root_q, size: rd.size};
				mem_re    = !comp_stop;
				mem_raddr = rd.parent;
			end
			ST_MERGE: begin
				mem_we    = root_q != r1_q;
				mem_waddr = r1_joins ? r1_q : root_q;
				mem_wdata = r1_joins ? entry_t'{occ: 1'b1, parent: root_q, size: r1size_q}
						     : entry_t'{occ: 1'b1, parent: r1_q, size: rootsize_q};
			end
			ST_MERGE2: begin
				mem_we    = 1'b1;
				mem_waddr = wp_addr_q;
				mem_wdata = wp_data_q;
			end
			ST_SCAN: begin
				mem_re    = line_q != LN_DONE && idx_q < ln_end;
				mem_raddr = AW'(idx_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			done_q     <= 1'b0;
			big_size_q <= '0;
			big_root_q <= '0;
			total_q    <= '0;
			k_q        <= '0;
			line_q     <= LN_TOP;
			caller_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(SITES - 1)) state_q <= ST_IDLE;
					else clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (start) begin
						site_q   <= AW'(cmd.site);
						nbv_q    <= cmd.neighbor_valid;
						nb_q[0]  <= cmd.neighbor_a;
						nb_q[1]  <= cmd.neighbor_b;
						nb_q[2]  <= cmd.neighbor_c;
						nb_q[3]  <= cmd.neighbor_d;
						nb_q[4]  <= cmd.neighbor_e;
						nb_q[5]  <= cmd.neighbor_f;
						nb_q[6]  <= cmd.neighbor_g;
						nb_q[7]  <= cmd.neighbor_h;
						k_q      <= '0;
						if (cmd.func == FUNC_START) begin
							big_size_q <= '0;
							big_root_q <= '0;
							total_q    <= '0;
							clr_q      <= '0;
							result_q   <= '0;
							done_q     <= 1'b1;
							state_q    <= ST_CLEAR;
						end else if (site_ok) begin
							state_q <= ST_CHK;
						end else begin
							state_q <= ST_SPAN;
						end
					end
				end
				ST_CHK: begin
					if (rd.occ) begin
						state_q <= ST_SPAN;
					end else begin
						r1_q     <= site_q;
						r1size_q <= (AW+1)'(1);
						if (total_q == '0) big_root_q <= site_q;
						total_q  <= total_q + 1'b1;
						state_q  <= ST_NB;
					end
				end
				ST_NB: begin
					if (k_q == KW'(MAX_NEIGHBORS)) begin
						state_q <= ST_SPAN;
					end else begin
						k_q <= k_q + 1'b1;
						if (nb_ok) begin
							cur_q    <= AW'(nb_sel);
							fstart_q <= AW'(nb_sel);
							caller_q <= 1'b0;
							state_q  <= ST_NB_CHK;
						end
					end
				end
				ST_NB_CHK: begin
					state_q <= rd.occ ? ST_WALK : ST_NB;
				end
				ST_WALK: begin
					if (rd.parent == cur_q) begin
						root_q     <= cur_q;
						rootsize_q <= rd.size;
						cur_q      <= fstart_q;
						state_q    <= ST_COMP;
					end else begin
						cur_q <= rd.parent;
					end
				end
				ST_COMP: begin
					if (comp_stop) state_q <= caller_q ? ST_SCAN_CMP : ST_MERGE;
					else cur_q <= rd.parent;
				end
				ST_MERGE: begin
					if (root_q == r1_q) begin
						state_q <= ST_NB;
					end else begin
						if (r1_joins) begin
							wp_addr_q <= root_q;
							wp_data_q <= '{occ: 1'b1, parent: root_q, size: sum};
							r1_q      <= root_q;
						end else begin
							wp_addr_q <= r1_q;
							wp_data_q <= '{occ: 1'b1, parent: r1_q, size: sum};
						end
						r1size_q <= sum;
						if (sum > big_size_q) begin
							big_size_q <= sum;
							big_root_q <= r1_joins ? root_q : r1_q;
						end
						state_q <= ST_MERGE2;
					end
				end
				ST_MERGE2: begin
					state_q <= ST_NB;
				end
				ST_SPAN: begin
					if (total_q == '0) begin
						result_q <= '{spans: 1'b0, sites_added: CountW'(total_q),
							largest_size: CountW'(big_size_q),
							largest_label: SiteW'(big_root_q)};
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						line_q  <= LN_TOP;
						idx_q   <= line_start(LN_TOP);
						flags_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (line_q == LN_DONE) begin
						result_q <= '{spans: (flags_q[0] & flags_q[1]) | (flags_q[2] & flags_q[3]),
							sites_added: CountW'(total_q),
							largest_size: CountW'(big_size_q),
							largest_label: SiteW'(big_root_q)};
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (idx_q >= ln_end) begin
						line_q <= line_q + 1'b1;
						idx_q  <= line_start(line_q + 1'b1);
					end else begin
						cur_q    <= AW'(idx_q);
						fstart_q <= AW'(idx_q);
						caller_q <= 1'b1;
						state_q  <= ST_SCAN_CHK;
					end
				end
				ST_SCAN_CHK: begin
					if (rd.occ) begin
						state_q <= ST_WALK;
					end else begin
						idx_q   <= idx_q + ln_step;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN_CMP: begin
					if (root_q == big_root_q) begin
						flags_q[line_q[1:0]] <= 1'b1;
						line_q <= line_q + 1'b1;
						idx_q  <= line_start(line_q + 1'b1);
					end else begin
						idx_q <= idx_q + ln_step;
					end
					state_q <= ST_SCAN;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

	// checks
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done || $past(start)))
		else $error("result strobe held for two cycles without a new item");
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		big_size_q <= total_q)
		else $error("largest cluster larger than occupied count");
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && mem_waddr == mem_raddr))
		else $error("read and write to the same site in one cycle");
	a_span_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.spans) |-> result.sites_added != '0)
		else $error("spanning reported with no occupied site");

endmodule
`default_nettype wire

// ===== tb/tb_union_find_percolation_engine.sv =====
// self-checking testbench for the union-find percolation engine
// depends on ufp_pkg and union_find_percolation_engine; a directed table, then random strip runs
`default_nettype none
module tb_union_find_percolation_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import ufp_pkg::*;

	localparam int SIDE      = 64;
	localparam int SITES     = 4096;
	localparam int NB        = 8;
	localparam int RAND_ITEMS = 570;
	localparam int DRAIN     = 4000;
	localparam longint LIMIT = 40000000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_item_t  cmd = '0;
	logic      done;
	out_item_t result;

	union_find_percolation_engine #(.SIDE(SIDE), .SITES(SITES), .MAX_NEIGHBORS(NB)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// lattice shadow state
	bit        lat_occ [SITES];
	int        lat_parent [SITES];
	int        lat_size [SITES];
	int        top_size, top_root, n_occupied;
	int        spans_seen;

	out_item_t expected_results [$];
	int        mismatches;
	int        results_seen;
	longint    cycles;

	function automatic void clear_lattice();
		for (int i = 0; i < SITES; i++) begin
			lat_occ[i] = 0;
			lat_parent[i] = 0;
			lat_size[i] = 0;
		end
		top_size = 0;
		top_root = 0;
		n_occupied = 0;
	endfunction

	// root find with path compression
	function automatic int root_of(int s);
		int r;
		int n;
		int nxt;
		r = s;
		n = 0;
		while (lat_parent[r] != r && n < SITES) begin
			r = lat_parent[r] % SITES;
			n++;
		end
		n = 0;
		while (lat_parent[s] != r && s != r && n < SITES) begin
			nxt = lat_parent[s] % SITES;
			lat_parent[s] = r;
			s = nxt;
			n++;
		end
		return r;
	endfunction

	function automatic bit member(int s, int r);
		if (s >= SITES || !lat_occ[s])
			return 0;
		return root_of(s) == r;
	endfunction

	// boundary scan of the tracked cluster
	function automatic bit crosses(int r);
		bit t, b, l, rt;
		t = 0; b = 0; l = 0; rt = 0;
		for (int i = 0; i < SIDE; i++)
			if (member(i, r)) t = 1;
		for (int i = SITES - SIDE; i < SITES; i++)
			if (member(i, r)) b = 1;
		for (int i = 0; i < SITES; i += SIDE)
			if (member(i, r)) l = 1;
		for (int i = SIDE - 1; i < SITES; i += SIDE)
			if (member(i, r)) rt = 1;
		return (t && b) || (l && rt);
	endfunction

	// apply one item to the shadow lattice and form its result
	function automatic out_item_t occupy_and_report(in_item_t it);
		out_item_t o;
		logic [SiteW-1:0] nbs [NB];
		int r1, r2, s, nb;
		o = '0;
		if (it.func == FUNC_START) begin
			clear_lattice();
			return o;
		end
		nbs[0] = it.neighbor_a; nbs[1] = it.neighbor_b;
		nbs[2] = it.neighbor_c; nbs[3] = it.neighbor_d;
		nbs[4] = it.neighbor_e; nbs[5] = it.neighbor_f;
		nbs[6] = it.neighbor_g; nbs[7] = it.neighbor_h;
		s = it.site;
		if (s < SITES && !lat_occ[s]) begin
			r1 = s;
			lat_occ[s] = 1;
			lat_parent[s] = s;
			lat_size[s] = 1;
			if (n_occupied == 0)
				top_root = s;
			n_occupied++;
			for (int k = 0; k < NB; k++) begin
				nb = nbs[k];
				if (it.neighbor_valid[k] && nb < SITES && lat_occ[nb]) begin
					r2 = root_of(nb);
					if (r2 != r1) begin
						if (lat_size[r1] < lat_size[r2]) begin
							lat_size[r2] += lat_size[r1];
							lat_parent[r1] = r2;
							r1 = r2;
						end else begin
							lat_size[r1] += lat_size[r2];
							lat_parent[r2] = r1;
						end
						if (lat_size[r1] > top_size) begin
							top_size = lat_size[r1];
							top_root = r1;
						end
					end
				end
			end
		end
		o.spans = (n_occupied > 0) ? crosses(top_root % SITES) : 1'b0;
		o.sites_added = n_occupied[CountW-1:0];
		o.largest_size = top_size[CountW-1:0];
		o.largest_label = top_root[SiteW-1:0];
		return o;
	endfunction

	function automatic in_item_t make_item(logic f, logic [SiteW-1:0] s, logic [7:0] v,
			logic [NB*SiteW-1:0] n);
		in_item_t it;
		it.func = f;
		it.site = s;
		it.neighbor_valid = v;
		{it.neighbor_h, it.neighbor_g, it.neighbor_f, it.neighbor_e,
			it.neighbor_d, it.neighbor_c, it.neighbor_b, it.neighbor_a} = n;
		return it;
	endfunction

	// real lattice neighbors of a site (random sites past the edge), with a random subset of slots marked valid
	function automatic in_item_t lattice_item(int s);
		logic [NB*SiteW-1:0] n;
		logic [7:0] v;
		int r, c, k;
		r = s / SIDE;
		c = s % SIDE;
		n = '0;
		v = '0;
		k = 0;
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++)
				if (!(dr == 0 && dc == 0)) begin
					if (r + dr >= 0 && r + dr < SIDE && c + dc >= 0 && c + dc < SIDE) begin
						n[k*SiteW +: SiteW] = SiteW'((r + dr) * SIDE + c + dc);
						// edge neighbors nearly always, diagonals now and then
						v[k] = (dr == 0 || dc == 0) ? ($urandom_range(0, 9) != 0)
							: ($urandom_range(0, 3) == 0);
					end else begin
						n[k*SiteW +: SiteW] = SiteW'($urandom);
						v[k] = 1'($urandom_range(0, 1));
					end
					k++;
				end
		return make_item(FUNC_ADD, s[SiteW-1:0], v, n);
	endfunction

	// send one item, predicting its result at the accepting edge
	task automatic send_item(in_item_t it, bit use_fixed, out_item_t fixed_exp);
		out_item_t p;
		@(negedge clk);
		cmd = it;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		p = occupy_and_report(it);
		if (p.spans)
			spans_seen++;
		expected_results.push_back(use_fixed ? fixed_exp : p);
		@(negedge clk);
		start = 1'b0;
		cmd = '0;
	endtask

	task automatic idle_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t e;
		if (done) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %p", result);
			end else begin
				e = expected_results.pop_front();
				if (result.spans !== e.spans || result.sites_added !== e.sites_added ||
						result.largest_size !== e.largest_size ||
						result.largest_label !== e.largest_label) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: spans %0d/%0d added %0d/%0d size %0d/%0d label %0d/%0d",
							e.spans, result.spans, e.sites_added, result.sites_added,
							e.largest_size, result.largest_size,
							e.largest_label, result.largest_label);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	typedef struct {
		in_item_t  it;
		bit        fixed;
		out_item_t exp;
	} dir_row_t;

	dir_row_t  dir_rows [$];
	int        occupied_list [$];

	initial begin
		dir_row_t row;
		in_item_t it;
		int gap_max, runs, sent, run_len, vertical, width, offset, s, idx;
		mismatches = 0;
		results_seen = 0;
		cycles = 0;
		spans_seen = 0;
		clear_lattice();

		// directed table: add before any start, start, ties, repeats, slot 7, far corners
		row.fixed = 1;
		row.it = make_item(FUNC_ADD, 12'd63, 8'h00, '0);
		row.exp = '{1'b0, 13'd1, 13'd0, 12'd63}; dir_rows.push_back(row);
		row.it = make_item(FUNC_START, 12'hFFF, 8'hFF, '1);
		row.exp = '0; dir_rows.push_back(row);
		row.it = make_item(FUNC_ADD, 12'd0, 8'h00, '0);
		row.exp = '{1'b0, 13'd1, 13'd0, 12'd0}; dir_rows.push_back(row);
		row.fixed = 0;
		row.it = make_item(FUNC_ADD, 12'd1, 8'h01, {84'd0, 12'd0}); dir_rows.push_back(row);
		row.fixed = 1;
		row.it = make_item(FUNC_ADD, 12'd0, 8'hFF, '0);
		row.exp = '{1'b0, 13'd2, 13'd2, 12'd1}; dir_rows.push_back(row);
		row.it = make_item(FUNC_ADD, 12'd4095, 8'hFF, '1);
		row.exp = '{1'b0, 13'd3, 13'd2, 12'd1}; dir_rows.push_back(row);
		row.fixed = 0;
		row.it = make_item(FUNC_ADD, 12'd2, 8'h80, {12'd1, 84'd0}); dir_rows.push_back(row);
		row.it = make_item(FUNC_ADD, 12'd64, 8'hFF, {{7{12'd4095}}, 12'd0});
		dir_rows.push_back(row);
		row.it = make_item(FUNC_ADD, 12'd128, 8'h00, {84'd0, 12'd64}); dir_rows.push_back(row);
		row.it = make_item(FUNC_ADD, 12'd4032, 8'hAA, {8{12'd4095}}); dir_rows.push_back(row);
		row.it = make_item(FUNC_ADD, 12'd4033, 8'h55, {8{12'd4032}}); dir_rows.push_back(row);
		row.fixed = 1;
		row.it = make_item(FUNC_START, 12'd0, 8'h00, '0);
		row.exp = '0; dir_rows.push_back(row);
		row.it = make_item(FUNC_ADD, 12'd4095, 8'h00, '1);
		row.exp = '{1'b0, 13'd1, 13'd0, 12'd4095}; dir_rows.push_back(row);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].exp);
			idle_cycles($urandom_range(0, 12));
		end

		// random runs: a start, then mostly adds inside a strip that can span
		sent = 0;
		runs = 0;
		while (sent < RAND_ITEMS) begin
			send_item(make_item(FUNC_START, SiteW'($urandom), 8'($urandom),
				{$urandom, $urandom, $urandom}), 0, '0);
			sent++;
			runs++;
			occupied_list.delete();
			run_len = $urandom_range(110, 170);
			vertical = $urandom_range(0, 1);
			width = $urandom_range(1, 3);
			offset = $urandom_range(0, SIDE - width);
			gap_max = (runs % 3 == 0) ? 0 : 12;
			for (int j = 0; j < run_len && sent < RAND_ITEMS; j++) begin
				idx = $urandom_range(0, 99);
				if (idx < 82) begin
					s = vertical ? $urandom_range(0, SIDE - 1) * SIDE + offset
						+ $urandom_range(0, width - 1)
						: (offset + $urandom_range(0, width - 1)) * SIDE
						+ $urandom_range(0, SIDE - 1);
					it = lattice_item(s);
				end else if (idx < 94 || occupied_list.size() == 0) begin
					it = make_item(FUNC_ADD, SiteW'($urandom), 8'($urandom),
						{$urandom, $urandom, $urandom});
				end else begin
					it = lattice_item(occupied_list[$urandom_range(0,
						occupied_list.size() - 1)]);
				end
				occupied_list.push_back(it.site);
				send_item(it, 0, '0);
				sent++;
				// hold off until the block has delivered everything once per run
				if (j == run_len / 2)
					wait (expected_results.size() == 0);
				idle_cycles($urandom_range(0, gap_max));
			end
		end

		wait (expected_results.size() == 0);
		repeat (DRAIN) @(posedge clk);
		$display("covered %0d items in %0d random runs, %0d results, %0d with spanning",
			sent + dir_rows.size(), runs, results_seen, spans_seen);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				expected_results.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
